### hdl/vector_beam_integrator_defines.svh
// ----------------------------------------------------------------------------
// vector beam integrator assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef VECTOR_BEAM_INTEGRATOR_DEFINES_SVH
`define VECTOR_BEAM_INTEGRATOR_DEFINES_SVH

// same-cycle implication
`define VBI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VBI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/vbi_pkg.sv
// ----------------------------------------------------------------------------
// vbi_pkg
// types and constants shared by the vector beam integrator
// ----------------------------------------------------------------------------
package vbi_pkg;

    // screen geometry
    localparam int unsigned SCREEN_WIDTH  = 32768;
    localparam int unsigned SCREEN_HEIGHT = 32768;
    localparam logic [31:0] CENTER_X      = 32'(SCREEN_WIDTH / 2);
    localparam logic [31:0] CENTER_Y      = 32'(SCREEN_HEIGHT / 2);
    localparam logic [31:0] LIMIT_X       = 32'(SCREEN_WIDTH);
    localparam logic [31:0] LIMIT_Y       = 32'(SCREEN_HEIGHT);

    // request kinds
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // port b and aux control bit positions
    localparam int unsigned PB_DEMUX_OFF_BIT = 0;
    localparam int unsigned PB_SEL_LSB       = 1;
    localparam int unsigned PB_RAMP_BIT      = 7;
    localparam int unsigned ACR_BLANK_BIT    = 4;
    localparam int unsigned ACR_RAMP_BIT     = 7;

    localparam logic [7:0] INTENSITY_OFFSET = 8'h80;
    localparam logic [7:0] HOLD_RESET       = 8'd128;

    // demultiplexer channel select
    typedef enum logic [1:0] {
        SEL_Y         = 2'd0,
        SEL_REF       = 2'd1,
        SEL_INTENSITY = 2'd2,
        SEL_SOUND     = 2'd3
    } sel_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] port_b;
        logic [7:0] dac_value;
        logic [7:0] joy_ch0;
        logic [7:0] joy_ch1;
        logic [7:0] joy_ch2;
        logic [7:0] joy_ch3;
        logic [7:0] aux_control;
        logic       blank_shift;
        logic       blank_hold;
        logic       zero_line;
        logic       timer_pb7;
    } req_t;

    typedef struct packed {
        logic        valid;
        logic [14:0] x0;
        logic [14:0] y0;
        logic [14:0] x1;
        logic [14:0] y1;
        logic [6:0]  color;
    } line_t;

    typedef struct packed {
        logic        compare_flag;
        logic        line_valid;
        logic [14:0] line_x0;
        logic [14:0] line_y0;
        logic [14:0] line_x1;
        logic [14:0] line_y1;
        logic [6:0]  line_color;
    } res_t;

    // which kind of step the pipeline performs this cycle
    typedef struct packed {
        logic update;
        logic tick;
    } step_t;

    // sample-and-hold values seen by the integrator
    typedef struct packed {
        logic [6:0] intensity;
        logic [8:0] delta_x;
        logic [8:0] delta_y;
    } hold_t;

endpackage

### hdl/vbi_if.sv
// ----------------------------------------------------------------------------
// vbi channel interfaces
// valid/ready channels for request and result beats
// ----------------------------------------------------------------------------
interface vbi_req_if import vbi_pkg::*; ();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface vbi_res_if import vbi_pkg::*; ();
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/vector_beam_integrator.sv
// ----------------------------------------------------------------------------
// vector_beam_integrator
// analog front end of a vector display: sample-and-holds, beam integrator
// and line segment extraction
// ----------------------------------------------------------------------------
// Every request beat produces exactly one result beat. An update beat (port b
// write) steers the dac value into the y, reference or intensity hold, picks
// the comparator channel and recomputes the deltas; a tick beat moves the beam
// one analog cycle and reports a finished line when blanking turns on or the
// slope or intensity changes. The block takes one beat per clock, back to back,
// while the result register drains: a request lands in the input register,
// then one register-to-register pass through the 32-bit beam add, the
// on-screen compare and the hold logic updates the state and fills the result
// register. The input register takes a new beat when it is empty or when its
// stored beat moves on, and a stored beat moves on only when the result
// register is empty or draining.
`include "vector_beam_integrator_defines.svh"

module vector_beam_integrator import vbi_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    vbi_req_if.sink   req,
    vbi_res_if.source res
);

    // input register
    logic  in_valid_reg, in_valid_next;
    req_t  in_data_reg;

    // result register
    logic  res_valid_reg, res_valid_next;
    res_t  res_data_reg;

    logic  step_fire;
    logic  req_accept;
    step_t step;
    hold_t hold;
    logic  compare_now;
    line_t line;

    // a stored request moves on when the result register is free or draining
    assign step_fire   = in_valid_reg && (!res_valid_reg || res.ready);
    assign req.ready   = !in_valid_reg || step_fire;
    assign req_accept  = req.valid && req.ready;
    assign step.update = step_fire && (in_data_reg.req_type == REQ_UPDATE);
    assign step.tick   = step_fire && (in_data_reg.req_type == REQ_TICK);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req_accept)
            in_valid_next = 1'b1;
        else if (step_fire)
            in_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (step_fire)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
            in_data_reg <= req.payload;
        if (step_fire)
        begin
            res_data_reg.compare_flag <= compare_now;
            res_data_reg.line_valid   <= line.valid;
            res_data_reg.line_x0      <= line.x0;
            res_data_reg.line_y0      <= line.y0;
            res_data_reg.line_x1      <= line.x1;
            res_data_reg.line_y1      <= line.y1;
            res_data_reg.line_color   <= line.color;
        end
    end

    // holds, comparator and deltas: written by update beats
    vbi_sample_hold u_sample_hold (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data        (in_data_reg),
        .hold        (hold),
        .compare_now (compare_now)
    );

    // beam position and segment tracking: advanced by tick beats
    vbi_beam_tracker u_beam_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .data  (in_data_reg),
        .hold  (hold),
        .line  (line)
    );

    assign res.valid   = res_valid_reg;
    assign res.payload = res_data_reg;

    `VBI_ASSERT_NEXT(a_step_fills_result, step_fire, res_valid_reg,
        "result register empty after a step")
    `VBI_ASSERT_NEXT(a_stalled_request_kept, in_valid_reg && !step_fire, in_valid_reg,
        "stored request dropped without a step")
    `VBI_ASSERT_NOW(a_no_line_on_update, step.update, !line.valid,
        "line reported on an update beat")

endmodule

### hdl/vbi_sample_hold.sv
// ----------------------------------------------------------------------------
// vbi_sample_hold
// dac demultiplexer, sample-and-hold registers, comparator and deltas
// ----------------------------------------------------------------------------
module vbi_sample_hold import vbi_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  step_t step,
    input  req_t  data,
    output hold_t hold,
    output logic  compare_now
);

    logic [7:0] y_hold_reg, y_hold_next;
    logic [7:0] ref_hold_reg, ref_hold_next;
    logic [6:0] intensity_reg, intensity_next;
    logic [8:0] delta_x_reg, delta_x_next;
    logic [8:0] delta_y_reg, delta_y_next;
    logic       compare_reg, compare_next;
    logic [7:0] joy_sel;
    logic [6:0] intensity_calc;
    logic       demux_on;
    sel_t       sel;

    always_comb
    begin
        sel            = sel_t'(data.port_b[PB_SEL_LSB +: 2]);
        demux_on       = !data.port_b[PB_DEMUX_OFF_BIT];
        intensity_calc = (data.dac_value > INTENSITY_OFFSET)
                       ? 7'(data.dac_value - INTENSITY_OFFSET) : 7'd0;
        y_hold_next    = y_hold_reg;
        ref_hold_next  = ref_hold_reg;
        intensity_next = intensity_reg;
        case (sel)
            SEL_Y:
            begin
                joy_sel = data.joy_ch0;
                if (demux_on) y_hold_next = data.dac_value;
            end
            SEL_REF:
            begin
                joy_sel = data.joy_ch1;
                if (demux_on) ref_hold_next = data.dac_value;
            end
            SEL_INTENSITY:
            begin
                joy_sel = data.joy_ch2;
                if (demux_on) intensity_next = intensity_calc;
            end
            default:
            begin
                // sound channel: comparator only
                joy_sel = data.joy_ch3;
            end
        endcase
        compare_next = (joy_sel > data.dac_value);
        delta_x_next = {1'b0, data.dac_value} - {1'b0, ref_hold_next};
        delta_y_next = {1'b0, ref_hold_next} - {1'b0, y_hold_next};
        compare_now  = step.update ? compare_next : compare_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_hold_reg    <= HOLD_RESET;
            ref_hold_reg  <= HOLD_RESET;
            intensity_reg <= '0;
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            compare_reg   <= 1'b0;
        end
        else if (step.update)
        begin
            y_hold_reg    <= y_hold_next;
            ref_hold_reg  <= ref_hold_next;
            intensity_reg <= intensity_next;
            delta_x_reg   <= delta_x_next;
            delta_y_reg   <= delta_y_next;
            compare_reg   <= compare_next;
        end
    end

    assign hold.intensity = intensity_reg;
    assign hold.delta_x   = delta_x_reg;
    assign hold.delta_y   = delta_y_reg;

endmodule

### hdl/vbi_beam_tracker.sv
// ----------------------------------------------------------------------------
// vbi_beam_tracker
// beam position integrator and line segment tracker
// ----------------------------------------------------------------------------
`include "vector_beam_integrator_defines.svh"

module vbi_beam_tracker import vbi_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  step_t step,
    input  req_t  data,
    input  hold_t hold,
    output line_t line
);

    logic [31:0] beam_x_reg, beam_x_next;
    logic [31:0] beam_y_reg, beam_y_next;
    logic        drawing_reg, drawing_next;
    logic [14:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [14:0] end_x_next, end_y_next;
    logic [31:0] slope_x_reg, slope_y_reg;
    logic [6:0]  color_reg;

    logic [31:0] sx, sy;
    logic        blank, ramp, on_old, on_new, slope_chg;
    logic        start, emit;

    always_comb
    begin
        blank = data.aux_control[ACR_BLANK_BIT] ? data.blank_shift : data.blank_hold;
        ramp  = data.aux_control[ACR_RAMP_BIT] ? data.timer_pb7
                                               : data.port_b[PB_RAMP_BIT];

        // zero line pulls straight to center, so the sum is the center itself
        if (!data.zero_line)
        begin
            sx          = CENTER_X - beam_x_reg;
            sy          = CENTER_Y - beam_y_reg;
            beam_x_next = CENTER_X;
            beam_y_next = CENTER_Y;
        end
        else if (ramp)
        begin
            sx          = '0;
            sy          = '0;
            beam_x_next = beam_x_reg;
            beam_y_next = beam_y_reg;
        end
        else
        begin
            sx          = {{23{hold.delta_x[8]}}, hold.delta_x};
            sy          = {{23{hold.delta_y[8]}}, hold.delta_y};
            beam_x_next = beam_x_reg + sx;
            beam_y_next = beam_y_reg + sy;
        end

        on_old    = (beam_x_reg < LIMIT_X) && (beam_y_reg < LIMIT_Y);
        on_new    = (beam_x_next < LIMIT_X) && (beam_y_next < LIMIT_Y);
        slope_chg = (sx != slope_x_reg) || (sy != slope_y_reg)
                 || (hold.intensity != color_reg);

        drawing_next = drawing_reg;
        start        = 1'b0;
        emit         = 1'b0;
        // only tick beats touch the segment
        if (step.tick)
        begin
            if (!drawing_reg)
            begin
                if (blank && on_old)
                begin
                    start        = 1'b1;
                    drawing_next = 1'b1;
                end
            end
            else if (!blank)
            begin
                emit         = 1'b1;
                drawing_next = 1'b0;
            end
            else if (slope_chg)
            begin
                emit         = 1'b1;
                start        = on_old;
                drawing_next = on_old;
            end
        end

        if (drawing_next && on_new)
        begin
            end_x_next = beam_x_next[14:0];
            end_y_next = beam_y_next[14:0];
        end
        else if (start)
        begin
            end_x_next = beam_x_reg[14:0];
            end_y_next = beam_y_reg[14:0];
        end
        else
        begin
            end_x_next = end_x_reg;
            end_y_next = end_y_reg;
        end

        line.valid = emit;
        line.x0    = emit ? start_x_reg : '0;
        line.y0    = emit ? start_y_reg : '0;
        line.x1    = emit ? end_x_reg   : '0;
        line.y1    = emit ? end_y_reg   : '0;
        line.color = emit ? color_reg   : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_x_reg  <= CENTER_X;
            beam_y_reg  <= CENTER_Y;
            drawing_reg <= 1'b0;
        end
        else if (step.tick)
        begin
            beam_x_reg  <= beam_x_next;
            beam_y_reg  <= beam_y_next;
            drawing_reg <= drawing_next;
        end
    end

    // segment payload, only read while drawing
    always_ff @(posedge clk)
    begin
        if (step.tick)
        begin
            end_x_reg <= end_x_next;
            end_y_reg <= end_y_next;
            if (start)
            begin
                start_x_reg <= beam_x_reg[14:0];
                start_y_reg <= beam_y_reg[14:0];
                slope_x_reg <= sx;
                slope_y_reg <= sy;
                color_reg   <= hold.intensity;
            end
        end
    end

    `VBI_ASSERT_NEXT(a_beam_holds_on_update, step.update,
        $stable(beam_x_reg) && $stable(beam_y_reg), "beam moved on an update step")
    `VBI_ASSERT_NEXT(a_drawing_holds_on_update, step.update,
        $stable(drawing_reg), "drawing state changed on an update step")
    `VBI_ASSERT_NOW(a_emit_needs_drawing, emit, drawing_reg,
        "line emitted with no segment in progress")

endmodule

### dv/vbi_line_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vbi_line_checker
// watches both channels of the beam integrator, predicts each result beat
// from the accepted request beats and compares them field by field
// ----------------------------------------------------------------------------
module vbi_line_checker import vbi_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    vbi_req_if   req,
    vbi_res_if   res,
    output int   mismatches,
    output int   in_flight
);

    // predicted analog state
    logic [7:0]  ref_level;
    logic [7:0]  y_level;
    logic [6:0]  glow;
    logic [7:0]  joy_level;
    logic        cmp_bit;
    logic [31:0] step_x;
    logic [31:0] step_y;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic        pen_down;
    logic [14:0] seg_x0;
    logic [14:0] seg_y0;
    logic [14:0] seg_x1;
    logic [14:0] seg_y1;
    logic [31:0] seg_dx;
    logic [31:0] seg_dy;
    logic [6:0]  seg_glow;

    res_t pending_lines[$];
    int   fail_count;

    function automatic bit visible(logic [31:0] x, logic [31:0] y);
        return (x < LIMIT_X) && (y < LIMIT_Y);
    endfunction

    function res_t finished_line();
        res_t r;
        r = '0;
        r.line_valid = 1'b1;
        r.line_x0    = seg_x0;
        r.line_y0    = seg_y0;
        r.line_x1    = seg_x1;
        r.line_y1    = seg_y1;
        r.line_color = seg_glow;
        return r;
    endfunction

    task open_segment(input logic [31:0] sx, input logic [31:0] sy);
        pen_down = 1'b1;
        seg_x0   = pos_x[14:0];
        seg_y0   = pos_y[14:0];
        seg_x1   = pos_x[14:0];
        seg_y1   = pos_y[14:0];
        seg_dx   = sx;
        seg_dy   = sy;
        seg_glow = glow;
    endtask

    // one request beat through the sample-and-holds and the integrator
    task advance_beam(input req_t b, output res_t r);
        logic [31:0] sx;
        logic [31:0] sy;
        logic        beam_on;
        logic        ramp;
        logic [7:0]  dac;
        r = '0;
        if (b.req_type == REQ_UPDATE)
        begin
            dac = b.dac_value;
            case (sel_t'(b.port_b[PB_SEL_LSB +: 2]))
                SEL_Y:
                begin
                    joy_level = b.joy_ch0;
                    if (!b.port_b[PB_DEMUX_OFF_BIT]) y_level = dac;
                end
                SEL_REF:
                begin
                    joy_level = b.joy_ch1;
                    if (!b.port_b[PB_DEMUX_OFF_BIT]) ref_level = dac;
                end
                SEL_INTENSITY:
                begin
                    joy_level = b.joy_ch2;
                    if (!b.port_b[PB_DEMUX_OFF_BIT])
                        glow = (dac > INTENSITY_OFFSET) ? 7'(dac - INTENSITY_OFFSET) : 7'd0;
                end
                default:
                    joy_level = b.joy_ch3;
            endcase
            cmp_bit = (joy_level > dac);
            step_x  = 32'(dac) - 32'(ref_level);
            step_y  = 32'(ref_level) - 32'(y_level);
        end
        else
        begin
            beam_on = b.aux_control[ACR_BLANK_BIT] ? b.blank_shift : b.blank_hold;
            if (!b.zero_line)
            begin
                sx = CENTER_X - pos_x;
                sy = CENTER_Y - pos_y;
            end
            else
            begin
                ramp = b.aux_control[ACR_RAMP_BIT] ? b.timer_pb7 : b.port_b[PB_RAMP_BIT];
                sx   = ramp ? 32'd0 : step_x;
                sy   = ramp ? 32'd0 : step_y;
            end
            if (!pen_down)
            begin
                if (beam_on && visible(pos_x, pos_y)) open_segment(sx, sy);
            end
            else if (!beam_on)
            begin
                pen_down = 1'b0;
                r = finished_line();
            end
            else if (sx != seg_dx || sy != seg_dy || glow != seg_glow)
            begin
                r = finished_line();
                if (visible(pos_x, pos_y)) open_segment(sx, sy);
                else pen_down = 1'b0;
            end
            pos_x = pos_x + sx;
            pos_y = pos_y + sy;
            if (pen_down && visible(pos_x, pos_y))
            begin
                seg_x1 = pos_x[14:0];
                seg_y1 = pos_y[14:0];
            end
        end
        r.compare_flag = cmp_bit;
    endtask

    task check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            ref_level  = HOLD_RESET;
            y_level    = HOLD_RESET;
            glow       = '0;
            joy_level  = HOLD_RESET;
            cmp_bit    = 1'b0;
            step_x     = '0;
            step_y     = '0;
            pos_x      = CENTER_X;
            pos_y      = CENTER_Y;
            pen_down   = 1'b0;
            seg_x0     = '0;
            seg_y0     = '0;
            seg_x1     = '0;
            seg_y1     = '0;
            seg_dx     = '0;
            seg_dy     = '0;
            seg_glow   = '0;
            fail_count = 0;
            pending_lines.delete();
            mismatches <= 0;
            in_flight  <= 0;
        end
        else
        begin
            // results leaving now belong to earlier requests
            if (res.valid && res.ready)
            begin
                got = res.payload;
                if (pending_lines.size() == 0)
                begin
                    $error("result beat with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    want = pending_lines.pop_front();
                    check_field("compare_flag", want.compare_flag, got.compare_flag);
                    check_field("line_valid", want.line_valid, got.line_valid);
                    check_field("line_x0", want.line_x0, got.line_x0);
                    check_field("line_y0", want.line_y0, got.line_y0);
                    check_field("line_x1", want.line_x1, got.line_x1);
                    check_field("line_y1", want.line_y1, got.line_y1);
                    check_field("line_color", want.line_color, got.line_color);
                end
            end
            if (req.valid && req.ready)
            begin
                advance_beam(req.payload, want);
                pending_lines.push_back(want);
            end
            mismatches <= fail_count;
            in_flight  <= pending_lines.size();
        end
    end

endmodule

### dv/vector_beam_integrator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_beam_integrator_test
// drives port b writes and analog ticks into the beam integrator, with random
// gaps and stalls on both channels, and reports the checker's verdict
// ----------------------------------------------------------------------------
module vector_beam_integrator_test;
    import vbi_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_BEATS   = 1600;
    localparam int CALM_TAIL      = 200;   // beats at the end with no idling
    localparam int HOLD_OFF_AT    = 600;   // receiver cycle where the long stall starts
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_CYCLES   = 8;     // quiet wait after the last result
    localparam int WATCHDOG_LIMIT = 3000;  // well past the long stall

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    vbi_req_if req_ch ();
    vbi_res_if res_ch ();

    int mismatches;
    int in_flight;
    int beats_sent = 0;
    int beat_goal  = RANDOM_BEATS;
    bit calm       = 1'b0;  // set for the last part: both sides stop idling
    bit send_gaps  = 1'b1;

    always #HALF_PERIOD clk = ~clk;

    vector_beam_integrator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    vbi_line_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    // ------------------------------------------------------------------------
    // beat builders
    // ------------------------------------------------------------------------

    // fully random beat, every bit of every field free
    function automatic req_t any_beat();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(req_t)-1:0];
    endfunction

    // port b write: select and demux bit forced, the rest random
    function automatic req_t port_write(sel_t sel, bit demux_off, logic [7:0] dac);
        req_t b;
        b = any_beat();
        b.req_type                    = REQ_UPDATE;
        b.port_b[PB_SEL_LSB +: 2]     = sel;
        b.port_b[PB_DEMUX_OFF_BIT]    = demux_off;
        b.dac_value                   = dac;
        return b;
    endfunction

    // analog tick: blank, zero and ramp forced through whichever source
    // the random aux control picks
    function automatic req_t analog_tick(bit beam_on, bit zero_n, bit ramp);
        req_t b;
        b = any_beat();
        b.req_type  = REQ_TICK;
        b.zero_line = zero_n;
        if (b.aux_control[ACR_BLANK_BIT]) b.blank_shift = beam_on;
        else b.blank_hold = beam_on;
        if (b.aux_control[ACR_RAMP_BIT]) b.timer_pb7 = ramp;
        else b.port_b[PB_RAMP_BIT] = ramp;
        return b;
    endfunction

    // dac level that leans toward the rails so the deltas get large
    function automatic logic [7:0] wide_level();
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom());
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offer one beat at the falling edge and hold it until accepted;
    // valid stays high into the next beat unless a gap is taken
    task send_beat(input req_t b);
        int gap;
        @(negedge clk);
        if ($urandom_range(0, 99) == 0) send_gaps = 1'($urandom_range(0, 1));
        if (!calm && send_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            req_ch.valid   <= 1'b0;
            req_ch.payload <= any_beat();
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= b;
        do @(posedge clk); while (!req_ch.ready);
        beats_sent++;
        if (beats_sent >= beat_goal - CALM_TAIL) calm = 1'b1;
    endtask

    // a drawn stroke: load ref, y and intensity, then a run of lit ticks
    // with the odd ramp or mid-stroke write, then blank the beam
    task draw_stroke();
        int run;
        int pick;
        send_beat(port_write(SEL_REF, 1'b0, wide_level()));
        send_beat(port_write(SEL_Y, 1'b0, wide_level()));
        send_beat(port_write(SEL_INTENSITY, 1'b0, 8'($urandom())));
        // long runs carry the beam off screen
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 30);
        for (int i = 0; i < run; i++)
        begin
            pick = $urandom_range(0, 39);
            if (pick < 2)
                send_beat(analog_tick(1'b1, 1'b1, 1'b1));
            else if (pick < 4)
                send_beat(port_write(sel_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                     8'($urandom())));
            else if (pick == 4)
                send_beat(analog_tick(1'b1, 1'b0, 1'($urandom_range(0, 1))));
            else
                send_beat(analog_tick(1'b1, 1'b1, 1'b0));
        end
        send_beat(analog_tick(1'b0, 1'b1, 1'($urandom_range(0, 1))));
    endtask

    initial
    begin
        req_t b;
        int   pick;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        res_ch.ready   = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --------------------------------------------------------------------
        // directed part
        // --------------------------------------------------------------------
        // dark tick: no line, line fields all zero
        send_beat(analog_tick(1'b0, 1'b1, 1'b0));
        send_beat(port_write(SEL_REF, 1'b0, 8'h00));
        // sound select only moves the comparator to joystick channel 3
        b = port_write(SEL_SOUND, 1'b0, 8'h00);
        b.joy_ch3 = 8'hFF;
        send_beat(b);
        send_beat(port_write(SEL_Y, 1'b0, 8'hFF));
        // demux off: comparator channel changes, holds stay
        send_beat(port_write(SEL_Y, 1'b1, 8'h55));
        // full intensity, widest deltas
        send_beat(port_write(SEL_INTENSITY, 1'b0, 8'hFF));
        repeat (3) send_beat(analog_tick(1'b1, 1'b1, 1'b0));
        // intensity change while lit closes the segment
        send_beat(port_write(SEL_INTENSITY, 1'b0, 8'h90));
        send_beat(analog_tick(1'b1, 1'b1, 1'b0));
        // ramp from port b, then from the timer: slope drops to zero once
        b = analog_tick(1'b1, 1'b1, 1'b0);
        b.aux_control[ACR_RAMP_BIT] = 1'b0;
        b.port_b[PB_RAMP_BIT]       = 1'b1;
        send_beat(b);
        b = analog_tick(1'b1, 1'b1, 1'b0);
        b.aux_control[ACR_RAMP_BIT] = 1'b1;
        b.timer_pb7                 = 1'b1;
        send_beat(b);
        send_beat(analog_tick(1'b1, 1'b1, 1'b0));
        // blanking ends the stroke
        send_beat(analog_tick(1'b0, 1'b1, 1'b0));
        // zero line pulls the beam back to the centre
        send_beat(analog_tick(1'b1, 1'b0, 1'b0));
        send_beat(analog_tick(1'b0, 1'b0, 1'b1));
        // intensity at and below the offset clamps to zero
        send_beat(port_write(SEL_INTENSITY, 1'b0, 8'h80));
        send_beat(port_write(SEL_INTENSITY, 1'b0, 8'h00));
        // all-ones and all-zeros beats of both kinds
        send_beat('1);
        b = '1;
        b.req_type = REQ_UPDATE;
        send_beat(b);
        send_beat('0);
        b = '0;
        b.req_type = REQ_TICK;
        send_beat(b);
        send_beat(analog_tick(1'b0, 1'b1, 1'b0));

        // --------------------------------------------------------------------
        // random part: mostly strokes, some recentering, some noise
        // --------------------------------------------------------------------
        beat_goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < beat_goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                draw_stroke();
            else if (pick < 7)
                send_beat(analog_tick(1'($urandom_range(0, 1)), 1'b0,
                                      1'($urandom_range(0, 1))));
            else
                repeat ($urandom_range(1, 4)) send_beat(any_beat());
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // wait for every predicted result, then a few quiet cycles
        while (in_flight != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && in_flight == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random stall bursts, one long hold-off, steady at the end
    // ------------------------------------------------------------------------
    initial
    begin
        int  cycles;
        int  gap;
        bit  stall_gaps;
        bit  held_off;
        cycles     = 0;
        stall_gaps = 1'b1;
        held_off   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cycles++;
            if ($urandom_range(0, 199) == 0) stall_gaps = 1'($urandom_range(0, 1));
            if (!held_off && cycles >= HOLD_OFF_AT)
            begin
                // long hold-off: the sender keeps offering and the block backs up
                held_off = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge clk);
                cycles += HOLD_OFF_LEN;
                res_ch.ready <= 1'b1;
            end
            else if (!calm && stall_gaps && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 15);
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
                cycles += gap;
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles in a row with no beat accepted on either channel
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
